### design/fbc_pkg.sv
// Shared constants for the frustum box cull unit.
package fbc_pkg;

	localparam int NUM_PLANES = 4;
	localparam int NUM_AXES   = 3;
	localparam int COORD_W    = 16;
	localparam int NORMAL_W   = NUM_AXES * COORD_W;
	localparam int DOT_W      = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = NORMAL_W;

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END     = 4'd8;

	// Edges from an accepted start to the edge that samples its done strobe
	localparam int LATENCY = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic [NUM_PLANES-1:0]     plane_mask_t;

endpackage

### design/frustum_box_cull_unit.sv
// Top level of the frustum box cull unit: four-plane box test pipeline.
//
//  channel  | signals                                   | direction | flow
//  ---------+-------------------------------------------+-----------+----------------
//  command  | start, busy, box_min_*, box_max_*,        | in        | start & !busy
//           | clip_mask_in                              |           |
//  result   | done, visible, clip_mask_out              | out       | done, one cycle
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | valid & ready
//
// One box per clock; done is the registered valid bit of stage 4.
// Stages: corner select, 24 parallel 16x16 products, plane sums less offset,
// compare and mask. busy and cfg_ready are constant since nothing stalls.
// Reset clears the stage valid bits and the plane registers to zero.
module frustum_box_cull_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [fbc_pkg::COORD_W-1:0]  box_min_x,
	input  logic signed [fbc_pkg::COORD_W-1:0]  box_min_y,
	input  logic signed [fbc_pkg::COORD_W-1:0]  box_min_z,
	input  logic signed [fbc_pkg::COORD_W-1:0]  box_max_x,
	input  logic signed [fbc_pkg::COORD_W-1:0]  box_max_y,
	input  logic signed [fbc_pkg::COORD_W-1:0]  box_max_z,
	input  logic [fbc_pkg::NUM_PLANES-1:0]      clip_mask_in,
	output logic                                done,
	output logic                                visible,
	output logic [fbc_pkg::NUM_PLANES-1:0]      clip_mask_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fbc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fbc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fbc_pkg::*;

	logic [NORMAL_W-1:0] normal_q [NUM_PLANES];
	dot_t                offset_q [NUM_PLANES];

	coord_t      nrm      [NUM_PLANES][NUM_AXES];
	coord_t      lo       [NUM_AXES];
	coord_t      hi       [NUM_AXES];
	logic        accept;

	logic        valid_s1;
	plane_mask_t mask_s1;
	coord_t      far_s1   [NUM_PLANES][NUM_AXES];
	coord_t      near_s1  [NUM_PLANES][NUM_AXES];

	logic        valid_s2;
	plane_mask_t mask_s2;
	dot_t        rprod_s2 [NUM_PLANES][NUM_AXES];
	dot_t        aprod_s2 [NUM_PLANES][NUM_AXES];

	logic        valid_s3;
	plane_mask_t mask_s3;
	dot_t        rej_s3   [NUM_PLANES];
	dot_t        acc_s3   [NUM_PLANES];

	plane_mask_t reject;
	plane_mask_t contained;
	logic        culled;

	logic        valid_s4;
	logic        visible_s4;
	plane_mask_t mask_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				normal_q[p] <= '0;
				offset_q[p] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < REG_OFFSET0) begin
				normal_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index < REG_END) begin
				offset_q[cfg_index[1:0]] <= cfg_data[DOT_W-1:0];
			end
		end
	end

	always_comb begin
		lo[0] = box_min_x;
		lo[1] = box_min_y;
		lo[2] = box_min_z;
		hi[0] = box_max_x;
		hi[1] = box_max_y;
		hi[2] = box_max_z;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				nrm[p][a] = $signed(normal_q[p][a*COORD_W +: COORD_W]);
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: reject corner is the far one along the normal
	always_ff @(posedge clk) begin
		mask_s1 <= clip_mask_in;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				far_s1[p][a]  <= nrm[p][a][COORD_W-1] ? lo[a] : hi[a];
				near_s1[p][a] <= nrm[p][a][COORD_W-1] ? hi[a] : lo[a];
			end
		end
	end

	// Stage 2: products, 16x16 signed fits 32 bits
	always_ff @(posedge clk) begin
		mask_s2 <= mask_s1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				rprod_s2[p][a] <= DOT_W'(far_s1[p][a] * nrm[p][a]);
				aprod_s2[p][a] <= DOT_W'(near_s1[p][a] * nrm[p][a]);
			end
		end
	end

	// Stage 3: wrapping sums less offset
	always_ff @(posedge clk) begin
		mask_s3 <= mask_s2;
		for (int p = 0; p < NUM_PLANES; p++) begin
			rej_s3[p] <= rprod_s2[p][0] + rprod_s2[p][1] + rprod_s2[p][2] - offset_q[p];
			acc_s3[p] <= aprod_s2[p][0] + aprod_s2[p][1] + aprod_s2[p][2] - offset_q[p];
		end
	end

	// Once culled the mask is forced to zero, so plane order does not matter
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			reject[p]    = mask_s3[p] && (rej_s3[p][DOT_W-1] || (rej_s3[p] == '0));
			contained[p] = !acc_s3[p][DOT_W-1];
		end
		culled = |reject;
	end

	// Stage 4: result register
	always_ff @(posedge clk) begin
		visible_s4 <= !culled;
		mask_s4    <= culled ? '0 : (mask_s3 & ~contained);
	end

	assign done          = valid_s4;
	assign visible       = visible_s4;
	assign clip_mask_out = mask_s4;

endmodule

### design/fbc_checker.sv
// Port-level checks for the frustum box cull unit, bound to the top level.
module fbc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [fbc_pkg::NUM_PLANES-1:0] clip_mask_in,
	input logic                           done,
	input logic                           visible,
	input logic [fbc_pkg::NUM_PLANES-1:0] clip_mask_out
);
	import fbc_pkg::*;

	// Every accepted command yields exactly one result, at fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted command produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted command");

	a_culled_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !visible) |-> (clip_mask_out == '0))
		else $error("culled box left plane bits set");

	a_mask_subset: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((clip_mask_out & ~$past(clip_mask_in, LATENCY)) == '0))
		else $error("result mask has a plane that was not tested");

	a_no_planes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(clip_mask_in, LATENCY) == '0)) |-> visible)
		else $error("box culled with no plane tested");

endmodule

bind frustum_box_cull_unit fbc_checker u_fbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.clip_mask_in  (clip_mask_in),
	.done          (done),
	.visible       (visible),
	.clip_mask_out (clip_mask_out)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frustum box cull unit.
module testbench;
	import fbc_pkg::*;

	typedef struct packed {
		coord_t      lo_x, lo_y, lo_z;
		coord_t      hi_x, hi_y, hi_z;
		plane_mask_t mask;
	} box_cmd_t;

	typedef struct packed {
		logic        vis;
		plane_mask_t msk;
	} cull_res_t;

	typedef struct packed {
		logic [1:0]  plane_set;
		box_cmd_t    cmd;
		logic        typed;
		logic        vis;
		plane_mask_t msk;
	} dir_row_t;

	localparam int N_DIR      = 21;
	localparam int N_PHASES   = 9;
	localparam int PHASE_BOXES = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	coord_t                box_min_x, box_min_y, box_min_z;
	coord_t                box_max_x, box_max_y, box_max_z;
	plane_mask_t           clip_mask_in;
	logic                  done;
	logic                  visible;
	plane_mask_t           clip_mask_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// register mirror used by the predictor
	logic [NORMAL_W-1:0] plane_normal [NUM_PLANES];
	logic [DOT_W-1:0]    plane_offset [NUM_PLANES];
	// plane values to program next
	logic [NORMAL_W-1:0] next_normal [NUM_PLANES];
	logic [DOT_W-1:0]    next_offset [NUM_PLANES];

	cull_res_t pending_culls [$];
	int        mismatches;
	bit        gaps_on;

	// plane set 0: registers at reset, so any tested plane culls
	// plane set 1: directed planes programmed before those rows
	dir_row_t dir_rows [N_DIR] = '{
		'{0, '{0, 0, 0, 0, 0, 0, 4'h0}, 1, 1, 4'h0},
		'{0, '{-32768, -32768, -32768, 32767, 32767, 32767, 4'hF}, 1, 0, 4'h0},
		'{0, '{32767, 32767, 32767, -32768, -32768, -32768, 4'h0}, 1, 1, 4'h0},
		'{0, '{-5, -5, -5, 5, 5, 5, 4'h4}, 1, 0, 4'h0},
		'{1, '{-100, 0, 0, -100, 0, 0, 4'h1}, 1, 0, 4'h0},
		'{1, '{-100, 0, 0, -99, 0, 0, 4'h1}, 1, 1, 4'h0},
		'{1, '{-101, 0, 0, -99, 0, 0, 4'h1}, 1, 1, 4'h1},
		'{1, '{32767, -32768, -32768, 32767, 32767, 32767, 4'h1}, 1, 1, 4'h0},
		'{1, '{7, 8, 9, -7, -8, -9, 4'h0}, 1, 1, 4'h0},
		'{1, '{-32768, -32768, -32768, -32768, -32768, -32768, 4'h2}, 0, 0, 4'h0},
		'{1, '{-32768, -32768, -32768, 32767, 32767, 32767, 4'h2}, 0, 0, 4'h0},
		'{1, '{32767, 32767, 32767, 32767, 32767, 32767, 4'h4}, 0, 0, 4'h0},
		'{1, '{-32768, -32768, -32768, 32767, 32767, 32767, 4'h4}, 0, 0, 4'h0},
		'{1, '{-10, -10, -10, 10, 10, 10, 4'h8}, 0, 0, 4'h0},
		'{1, '{-3, 4, -2, 6, 9, 1, 4'h8}, 0, 0, 4'h0},
		'{1, '{-50, -50, -50, 50, 50, 50, 4'hF}, 0, 0, 4'h0},
		'{1, '{500, 500, 500, -500, -500, -500, 4'hF}, 0, 0, 4'h0},
		'{1, '{0, 0, 0, 0, 0, 0, 4'h3}, 0, 0, 4'h0},
		'{1, '{-1, -1, -1, 1, 1, 1, 4'hC}, 0, 0, 4'h0},
		'{1, '{-32768, -32768, -32768, 32767, 32767, 32767, 4'hF}, 0, 0, 4'h0},
		'{1, '{10, 20, 30, 40, 50, 60, 4'hE}, 0, 0, 4'h0}
	};

	frustum_box_cull_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_min_z    (box_min_z),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.box_max_z    (box_max_z),
		.clip_mask_in (clip_mask_in),
		.done         (done),
		.visible      (visible),
		.clip_mask_out(clip_mask_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	// Planes in order; the first rejecting plane stops the test.
	function automatic cull_res_t predict_cull(box_cmd_t b);
		coord_t      lo [3];
		coord_t      hi [3];
		int          n, far_c, near_c;
		logic [31:0] rej, acc;
		plane_mask_t m;
		logic        vis;
		cull_res_t   r;
		lo[0] = b.lo_x; lo[1] = b.lo_y; lo[2] = b.lo_z;
		hi[0] = b.hi_x; hi[1] = b.hi_y; hi[2] = b.hi_z;
		m = b.mask;
		vis = 1'b1;
		for (int p = 0; p < NUM_PLANES && vis; p++) begin
			if (m[p]) begin
				rej = '0;
				acc = '0;
				for (int a = 0; a < NUM_AXES; a++) begin
					n = int'($signed(plane_normal[p][a*COORD_W +: COORD_W]));
					far_c = (n >= 0) ? int'(hi[a]) : int'(lo[a]);
					near_c = (n >= 0) ? int'(lo[a]) : int'(hi[a]);
					rej = rej + far_c * n;
					acc = acc + near_c * n;
				end
				rej = rej - plane_offset[p];
				acc = acc - plane_offset[p];
				if (rej == 0 || rej[31])
					vis = 1'b0;
				else if (!acc[31])
					m[p] = 1'b0;
			end
		end
		r.vis = vis;
		r.msk = vis ? m : '0;
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] rand_comp();
		int v;
		if ($urandom_range(99) < 60)
			v = int'($urandom_range(128)) - 64;
		else
			v = $urandom;
		return v[COORD_W-1:0];
	endfunction

	function automatic box_cmd_t random_box();
		coord_t   lo [3];
		coord_t   hi [3];
		int       c, e, u, w, mode;
		box_cmd_t b;
		mode = $urandom_range(99);
		for (int a = 0; a < NUM_AXES; a++) begin
			if (mode < 65) begin
				// well-formed box near the origin
				c = int'($urandom_range(4000)) - 2000;
				e = $urandom_range(500);
				lo[a] = COORD_W'(c - e);
				hi[a] = COORD_W'(c + e);
			end else begin
				u = int'($signed(16'($urandom)));
				w = int'($signed(16'($urandom)));
				if (mode < 85 && u > w) begin
					lo[a] = COORD_W'(w);
					hi[a] = COORD_W'(u);
				end else begin
					lo[a] = COORD_W'(u);
					hi[a] = COORD_W'(w);
				end
			end
		end
		b.lo_x = lo[0]; b.lo_y = lo[1]; b.lo_z = lo[2];
		b.hi_x = hi[0]; b.hi_y = hi[1]; b.hi_z = hi[2];
		b.mask = plane_mask_t'($urandom_range(15));
		return b;
	endfunction

	// Tasks below start and end just after a falling edge.
	task automatic send_box(box_cmd_t b, cull_res_t exp_res);
		while (gaps_on && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		box_min_x    <= b.lo_x;
		box_min_y    <= b.lo_y;
		box_min_z    <= b.lo_z;
		box_max_x    <= b.hi_x;
		box_max_y    <= b.hi_y;
		box_max_z    <= b.hi_z;
		clip_mask_in <= b.mask;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_culls.push_back(exp_res);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		while (gaps_on && $urandom_range(99) < 27) begin
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < REG_OFFSET0)
			plane_normal[idx[1:0]] = data;
		else if (idx < REG_END)
			plane_offset[idx[1:0]] = data[DOT_W-1:0];
		@(negedge clk);
	endtask

	task automatic program_planes();
		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(CFG_IDX_W'(REG_NORMAL0 + p), next_normal[p]);
		// junk in the upper bits of an offset transfer must be dropped
		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(CFG_IDX_W'(REG_OFFSET0 + p), {16'($urandom), next_offset[p]});
		// unmapped index, must have no effect
		write_reg(CFG_IDX_W'(REG_END + $urandom_range(7)), {16'($urandom), 32'($urandom)});
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending_culls.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	always @(posedge clk) begin
		cull_res_t exp_res;
		if (arst_n && done) begin
			if (pending_culls.size() == 0) begin
				$error("unexpected result: visible %0d clip_mask_out %h", visible,
					clip_mask_out);
				mismatches++;
			end else begin
				exp_res = pending_culls.pop_front();
				if (visible !== exp_res.vis) begin
					$error("visible: expected %0d, got %0d", exp_res.vis, visible);
					mismatches++;
				end
				if (clip_mask_out !== exp_res.msk) begin
					$error("clip_mask_out: expected %h, got %h", exp_res.msk, clip_mask_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [1:0] cur_set;
		cull_res_t  exp_res;
		box_cmd_t   b;
		mismatches   = 0;
		gaps_on      = 1'b1;
		arst_n       = 1'b0;
		start        = 1'b0;
		box_min_x    = '0;
		box_min_y    = '0;
		box_min_z    = '0;
		box_max_x    = '0;
		box_max_y    = '0;
		box_max_z    = '0;
		clip_mask_in = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			plane_normal[p] = '0;
			plane_offset[p] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed planes: +x with offset -100, all-min normal, all-max normal
		// with most negative offset, mixed normal
		next_normal[0] = 48'h0000_0000_0001; next_offset[0] = -32'sd100;
		next_normal[1] = 48'h8000_8000_8000; next_offset[1] = 32'h0000_0000;
		next_normal[2] = 48'h7FFF_7FFF_7FFF; next_offset[2] = 32'h8000_0000;
		next_normal[3] = 48'hFFFD_0005_0000; next_offset[3] = 32'd7;
		cur_set = '0;
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].plane_set != cur_set) begin
				drain();
				program_planes();
				cur_set = dir_rows[i].plane_set;
			end
			if (dir_rows[i].typed) begin
				exp_res.vis = dir_rows[i].vis;
				exp_res.msk = dir_rows[i].msk;
			end else begin
				exp_res = predict_cull(dir_rows[i].cmd);
			end
			send_box(dir_rows[i].cmd, exp_res);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			gaps_on = (ph != 4);
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (ph == 0) begin
					next_normal[p] = 48'h8000_8000_8000;
					next_offset[p] = 32'h8000_0000;
				end else if (ph == 1) begin
					next_normal[p] = 48'h7FFF_7FFF_7FFF;
					next_offset[p] = 32'h7FFF_FFFF;
				end else begin
					next_normal[p] = {rand_comp(), rand_comp(), rand_comp()};
					if ($urandom_range(99) < 70)
						next_offset[p] = int'($urandom_range(40000)) - 20000;
					else
						next_offset[p] = $urandom;
				end
			end
			program_planes();
			for (int k = 0; k < PHASE_BOXES; k++) begin
				b = random_box();
				send_box(b, predict_cull(b));
			end
		end

		drain();
		repeat (LATENCY + 2) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
design/fbc_pkg.sv
design/frustum_box_cull_unit.sv
design/fbc_checker.sv
bench/testbench.sv
